// File: rtl/gasm_pkg.sv
// Shared types, constants and score arithmetic for the alignment score matrix core.
package gasm_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int SCORE_WIDTH = 32;

    localparam int COL_W    = $clog2(MAX_COLS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 2);
    localparam int IDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W    = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int PROD_W   = CNT_W + 18;
    localparam int EXT_W    = ((PROD_W > SCORE_WIDTH) ? PROD_W : SCORE_WIDTH) + 1;
    localparam int MATCH_W  = 18;
    localparam int OUT_W    = 32;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [1:0] REG_GAP        = 2'd1;
    localparam logic [1:0] REG_MISMATCH   = 2'd2;
    localparam logic [1:0] REG_STRINGENCY = 2'd3;

    typedef logic signed [SCORE_WIDTH-1:0] score_t;
    typedef logic signed [MATCH_W-1:0]     small_t;

    localparam score_t SCORE_MAX = {1'b0, {(SCORE_WIDTH - 1){1'b1}}};
    localparam score_t SCORE_MIN = {1'b1, {(SCORE_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic [10:0] row_length;
        logic [8:0]  gap_penalty;
        logic [8:0]  mismatch_score;
        logic [15:0] stringency;
    } cfg_t;

    typedef struct packed {
        logic             top;
        logic             first;
        logic             overflow;
        logic             last;
        logic [IDX_W-1:0] idx;
        score_t           up_b;
        score_t           diag_b;
        score_t           left_b;
        small_t           match;
    } cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0] cell_score;
        logic             final_cell;
        logic             row_overflow;
    } result_t;

    // Saturate a wide signed value to the score range
    function automatic score_t sat_ext(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(SCORE_MAX);
        lo = EXT_W'(SCORE_MIN);
        if (v > hi)
            return SCORE_MAX;
        else if (v < lo)
            return SCORE_MIN;
        else
            return v[SCORE_WIDTH-1:0];
    endfunction

    // Border value: count times gap, in Q.8, saturated
    function automatic score_t border(input logic [CNT_W-1:0] cnt,
                                      input logic [8:0] gap);
        logic signed [CNT_W:0]    c;
        logic signed [8:0]        g;
        logic signed [CNT_W+9:0]  p;
        logic signed [PROD_W-1:0] q;
        c = $signed({1'b0, cnt});
        g = $signed(gap);
        p = c * g;
        q = {p, 8'b0};
        return sat_ext(EXT_W'(q));
    endfunction

    // Score plus a small signed term, saturated
    function automatic score_t add_sat(input score_t a, input small_t b);
        logic [SCORE_WIDTH:0] s;
        s = {a[SCORE_WIDTH-1], a} + {{(SCORE_WIDTH + 1 - MATCH_W){b[MATCH_W-1]}}, b};
        if (s[SCORE_WIDTH] != s[SCORE_WIDTH-1])
            return s[SCORE_WIDTH] ? SCORE_MIN : SCORE_MAX;
        else
            return s[SCORE_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/gasm_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
module gasm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gasm_front.sv
// Front end: row/column tracking, border values and match classification per cell.
module gasm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  gasm_pkg::cfg_t    cfg,
    input  logic              push,
    input  logic              q_full,
    input  logic              pair_linked,
    input  logic [15:0]       pair_similarity,
    input  logic              last_cell,
    output logic              accept,
    output gasm_pkg::cmd_t    cmd
);

    logic [gasm_pkg::ROW_W-1:0] row_reg;
    logic [gasm_pkg::ROW_W-1:0] row_next;
    logic [gasm_pkg::COL_W-1:0] col_reg;
    logic [gasm_pkg::COL_W-1:0] col_next;
    logic [gasm_pkg::COL_W-1:0] len_eff;
    logic [31:0]                rl32;
    logic [gasm_pkg::CNT_W-1:0] row_c;
    logic [gasm_pkg::CNT_W-1:0] col_c;
    logic [gasm_pkg::CNT_W-1:0] diag_c;
    logic [gasm_pkg::COL_W-1:0] col_m1;

    assign accept = push & ~q_full;

    // Clamp the row length to 1..MAX_COLS
    always_comb
    begin
        rl32 = 32'(cfg.row_length);
        if (rl32 == 32'd0)
            len_eff = gasm_pkg::COL_W'(1);
        else if (rl32 > 32'(gasm_pkg::MAX_COLS))
            len_eff = gasm_pkg::COL_W'(gasm_pkg::MAX_COLS);
        else
            len_eff = gasm_pkg::COL_W'(cfg.row_length);
    end

    always_comb
    begin
        row_c  = gasm_pkg::CNT_W'(row_reg);
        col_c  = gasm_pkg::CNT_W'(col_reg);
        col_m1 = col_reg - gasm_pkg::COL_W'(1);
        diag_c = (col_reg == gasm_pkg::COL_W'(1)) ? (row_c - gasm_pkg::CNT_W'(1))
                                                  : (col_c - gasm_pkg::CNT_W'(1));

        cmd.top      = (row_reg == gasm_pkg::ROW_W'(1));
        cmd.first    = (col_reg == gasm_pkg::COL_W'(1));
        cmd.overflow = (row_reg > gasm_pkg::ROW_W'(gasm_pkg::MAX_ROWS));
        cmd.last     = last_cell;
        if (32'(col_m1) >= 32'(gasm_pkg::MAX_COLS))
            cmd.idx = gasm_pkg::IDX_W'(gasm_pkg::MAX_COLS - 1);
        else
            cmd.idx = col_m1[gasm_pkg::IDX_W-1:0];
        cmd.up_b   = gasm_pkg::border(col_c, cfg.gap_penalty);
        cmd.diag_b = gasm_pkg::border(diag_c, cfg.gap_penalty);
        cmd.left_b = gasm_pkg::border(row_c, cfg.gap_penalty);
        if (pair_linked && (pair_similarity >= cfg.stringency))
            cmd.match = {2'b00, pair_similarity};
        else
            cmd.match = {cfg.mismatch_score[8], cfg.mismatch_score, 8'b0};
    end

    // Advance the counters, wrap at row end, rewind on the final cell
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            priority if (last_cell)
            begin
                row_next = gasm_pkg::ROW_W'(1);
                col_next = gasm_pkg::COL_W'(1);
            end
            else if (col_reg >= len_eff)
            begin
                col_next = gasm_pkg::COL_W'(1);
                if (row_reg <= gasm_pkg::ROW_W'(gasm_pkg::MAX_ROWS))
                    row_next = row_reg + gasm_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + gasm_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= gasm_pkg::ROW_W'(1);
            col_reg <= gasm_pkg::COL_W'(1);
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// File: rtl/gasm_cmd_queue.sv
// Short command queue between the front end and the back end.
module gasm_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  gasm_pkg::cmd_t wr_cmd,
    input  logic           rd_en,
    output gasm_pkg::cmd_t rd_cmd,
    output logic           full,
    output logic           empty
);

    gasm_pkg::cmd_t                entries_reg [gasm_pkg::CMDQ_DEPTH];
    logic [gasm_pkg::CMDQ_AW-1:0]  wr_ptr_reg;
    logic [gasm_pkg::CMDQ_AW-1:0]  rd_ptr_reg;
    logic [gasm_pkg::CMDQ_AW:0]    count_reg;
    logic [gasm_pkg::CMDQ_AW:0]    count_next;

    assign full   = (count_reg == (gasm_pkg::CMDQ_AW + 1)'(gasm_pkg::CMDQ_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + (gasm_pkg::CMDQ_AW + 1)'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - (gasm_pkg::CMDQ_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + gasm_pkg::CMDQ_AW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + gasm_pkg::CMDQ_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// File: rtl/gasm_back.sv
// Back end: line store read, cell recurrence, neighbour registers and result queue.
module gasm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gasm_pkg::cfg_t             cfg,
    input  gasm_pkg::cmd_t             head,
    input  logic                       q_empty,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output logic [gasm_pkg::OUT_W-1:0] cell_score,
    output logic                       final_cell,
    output logic                       row_overflow
);

    // Compute stage
    logic                  a_valid_reg;
    gasm_pkg::cmd_t        a_cmd_reg;
    logic                  fwd_reg;
    gasm_pkg::score_t      fwd_data_reg;
    gasm_pkg::score_t      left_reg;
    gasm_pkg::score_t      left_next;
    gasm_pkg::score_t      diag_reg;
    gasm_pkg::score_t      diag_next;
    logic [gasm_pkg::SCORE_WIDTH-1:0] ram_rdata;

    gasm_pkg::score_t      up;
    gasm_pkg::score_t      diag;
    gasm_pkg::score_t      left;
    gasm_pkg::score_t      s_up;
    gasm_pkg::score_t      s_diag;
    gasm_pkg::score_t      s_left;
    gasm_pkg::score_t      cell_val;
    gasm_pkg::small_t      gap18;
    logic signed [63:0]    cell64;
    gasm_pkg::result_t     res;
    logic                  adv;
    logic                  ram_we;

    // Result queue, two entries
    gasm_pkg::result_t     oq_reg [2];
    logic                  oq_wr_reg;
    logic                  oq_rd_reg;
    logic [1:0]            oq_count_reg;
    logic [1:0]            oq_count_next;
    logic                  oq_push;
    logic                  oq_pop;

    assign adv    = (oq_count_reg != 2'd2);
    assign q_pop  = adv & ~q_empty;
    assign ram_we = adv & a_valid_reg & ~a_cmd_reg.overflow;
    assign gap18  = {cfg.gap_penalty[8], cfg.gap_penalty, 8'b0};

    gasm_ram #(
        .WIDTH (gasm_pkg::SCORE_WIDTH),
        .DEPTH (gasm_pkg::MAX_COLS)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_cmd_reg.idx),
        .wdata (cell_val),
        .re    (q_pop),
        .raddr (head.idx),
        .rdata (ram_rdata)
    );

    // Cell recurrence; take the just-written cell when the store read raced it
    always_comb
    begin
        if (a_cmd_reg.top)
            up = a_cmd_reg.up_b;
        else if (fwd_reg)
            up = fwd_data_reg;
        else
            up = ram_rdata;
        diag = (a_cmd_reg.top || a_cmd_reg.first) ? a_cmd_reg.diag_b : diag_reg;
        left = a_cmd_reg.first ? a_cmd_reg.left_b : left_reg;

        s_up     = gasm_pkg::add_sat(up, gap18);
        s_diag   = gasm_pkg::add_sat(diag, a_cmd_reg.match);
        s_left   = gasm_pkg::add_sat(left, gap18);
        cell_val = s_up;
        if (s_diag > cell_val)
            cell_val = s_diag;
        if (s_left > cell_val)
            cell_val = s_left;

        cell64           = 64'(cell_val);
        res.cell_score   = a_cmd_reg.overflow ? '0 : cell64[gasm_pkg::OUT_W-1:0];
        res.final_cell   = a_cmd_reg.last;
        res.row_overflow = a_cmd_reg.overflow;
    end

    always_comb
    begin
        left_next = left_reg;
        diag_next = diag_reg;
        if (adv && a_valid_reg)
        begin
            if (!a_cmd_reg.overflow)
            begin
                left_next = cell_val;
                diag_next = up;
            end
            if (a_cmd_reg.last)
            begin
                left_next = '0;
                diag_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            left_reg    <= '0;
            diag_reg    <= '0;
        end
        else
        begin
            left_reg <= left_next;
            diag_reg <= diag_next;
            if (adv)
            begin
                a_valid_reg <= ~q_empty;
                fwd_reg     <= ram_we & (a_cmd_reg.idx == head.idx);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_cmd_reg    <= head;
            fwd_data_reg <= cell_val;
        end
    end

    // Result queue
    assign oq_push      = adv & a_valid_reg;
    assign oq_pop       = pop & ~empty;
    assign empty        = (oq_count_reg == 2'd0);
    assign cell_score   = oq_reg[oq_rd_reg].cell_score;
    assign final_cell   = oq_reg[oq_rd_reg].final_cell;
    assign row_overflow = oq_reg[oq_rd_reg].row_overflow;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
            oq_count_next = oq_count_reg + 2'd1;
        else if (oq_pop && !oq_push)
            oq_count_next = oq_count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= ~oq_wr_reg;
            if (oq_pop)
                oq_rd_reg <= ~oq_rd_reg;
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_reg[oq_wr_reg] <= res;
    end

endmodule

// File: rtl/global_alignment_score_matrix_core.sv
// Top level of the global alignment score matrix core: register file and block wiring.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  ------------------------------------------
//  config    in/out     psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//  cell in   in         push / full            pair_linked, pair_similarity, last_cell
//  result    out        empty / pop            cell_score, final_cell, row_overflow
//
//  One cell per clock sustained unless a side stalls; a cell's score passes the command
//  queue, compute stage and result queue, paced by the back end's left-neighbour loop
//  (three saturating adds and a three-way maximum, unregistered). The line store is read
//  as a command leaves the queue; a read that races the write of the cell just finished
//  takes that cell instead. Reset clears counters, neighbour registers and queue pointers,
//  not the line store. Either side may stall: the command and result queues hold work.
module global_alignment_score_matrix_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Cell input
    input  logic        push,
    output logic        full,
    input  logic        pair_linked,
    input  logic [15:0] pair_similarity,
    input  logic        last_cell,
    // Results
    output logic        empty,
    input  logic        pop,
    output logic [31:0] cell_score,
    output logic        final_cell,
    output logic        row_overflow
);

    gasm_pkg::cfg_t cfg_reg;
    gasm_pkg::cfg_t cfg_next;
    gasm_pkg::cmd_t front_cmd;
    gasm_pkg::cmd_t head_cmd;
    logic           front_accept;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           cfg_wr;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign full    = q_full;

    // Register writes: keep only the register's own bits
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                gasm_pkg::REG_ROW_LENGTH: cfg_next.row_length     = pwdata[10:0];
                gasm_pkg::REG_GAP:        cfg_next.gap_penalty    = pwdata[8:0];
                gasm_pkg::REG_MISMATCH:   cfg_next.mismatch_score = pwdata[8:0];
                gasm_pkg::REG_STRINGENCY: cfg_next.stringency     = pwdata[15:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // Register reads return the raw stored bits, zero-extended
    always_comb
    begin
        unique case (reg_idx)
            gasm_pkg::REG_ROW_LENGTH: prdata = {21'b0, cfg_reg.row_length};
            gasm_pkg::REG_GAP:        prdata = {23'b0, cfg_reg.gap_penalty};
            gasm_pkg::REG_MISMATCH:   prdata = {23'b0, cfg_reg.mismatch_score};
            gasm_pkg::REG_STRINGENCY: prdata = {16'b0, cfg_reg.stringency};
            default:                  prdata = 32'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length     <= 11'd1;
            cfg_reg.gap_penalty    <= 9'h1FF;
            cfg_reg.mismatch_score <= 9'h1FF;
            cfg_reg.stringency     <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify each cell and work out its borders
    gasm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .push            (push),
        .q_full          (q_full),
        .pair_linked     (pair_linked),
        .pair_similarity (pair_similarity),
        .last_cell       (last_cell),
        .accept          (front_accept),
        .cmd             (front_cmd)
    );

    // Decouple the two halves
    gasm_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_accept),
        .wr_cmd (front_cmd),
        .rd_en  (q_pop),
        .rd_cmd (head_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Back end: recurrence, line store and result queue
    gasm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head_cmd),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .cell_score   (cell_score),
        .final_cell   (final_cell),
        .row_overflow (row_overflow)
    );

endmodule
